// File: design/wrbp_pkg.sv
package wrbp_pkg;

  localparam int unsigned CfgIndexWidth = 1;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_COMMAND_MODE   = 1'b0,
    CFG_OVERFLOW_LIMIT = 1'b1
  } cfg_reg_e;

  localparam logic       CommandModeReset   = 1'b1;
  localparam logic [7:0] OverflowLimitReset = 8'd150;

  localparam logic [7:0] ChO     = 8'h4F;
  localparam logic [7:0] ChK     = 8'h4B;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChY     = 8'h79;
  localparam logic [7:0] LinkUp0 = 8'h20;
  localparam logic [7:0] LinkUp1 = 8'h02;
  localparam logic [7:0] LinkDn0 = 8'h64;
  localparam logic [7:0] LinkDn1 = 8'h01;
  localparam logic [7:0] LinkDn2 = 8'h60;

  localparam logic [2:0] ReadyLast = 3'd4;

  function automatic logic [7:0] ready_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h72;
      3'd1:    ch = 8'h65;
      3'd2:    ch = 8'h61;
      3'd3:    ch = 8'h64;
      3'd4:    ch = 8'h79;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  typedef struct packed {
    logic [7:0]      byte_count;
    logic [2:0][7:0] recent;
    logic            o_seen;
    logic [2:0]      ready_progress;
    logic            link_up;
    logic [7:0]      payload_remaining;
    logic [7:0]      payload_position;
  } parse_state_t;

  typedef struct packed {
    logic       ack_found;
    logic       connected;
    logic       cmd_valid;
    logic [7:0] cmd_byte;
    logic [7:0] cmd_index;
    logic       cmd_last;
    logic       overflow;
  } parse_result_t;

endpackage

// File: design/wrbp_step.sv
module wrbp_step (
  input  wrbp_pkg::parse_state_t  state_i,
  input  logic [7:0]              rx_byte_i,
  input  logic                    command_mode_i,
  input  logic [7:0]              overflow_limit_i,
  output wrbp_pkg::parse_state_t  state_o,
  output wrbp_pkg::parse_result_t result_o
);

  logic       ok, gt, rdy, hit;
  logic [7:0] count_inc;
  logic [7:0] count_pre;
  logic [7:0] remaining_dec;

  assign ok  = state_i.o_seen && (rx_byte_i == wrbp_pkg::ChK);
  assign gt  = rx_byte_i == wrbp_pkg::ChGt;
  assign rdy = (state_i.ready_progress == wrbp_pkg::ReadyLast) &&
               (rx_byte_i == wrbp_pkg::ChY);
  assign hit = ok || gt || rdy;
  assign count_inc = (state_i.byte_count == 8'hFF) ? 8'hFF : state_i.byte_count + 8'd1;
  assign remaining_dec = state_i.payload_remaining - 8'd1;

  always_comb begin
    state_o   = state_i;
    result_o  = '0;
    count_pre = state_i.byte_count;

    if (command_mode_i) begin
      if (state_i.ready_progress < wrbp_pkg::ReadyLast &&
          rx_byte_i == wrbp_pkg::ready_char(state_i.ready_progress)) begin
        state_o.ready_progress = state_i.ready_progress + 3'd1;
      end else begin
        state_o.ready_progress = (rx_byte_i == wrbp_pkg::ChR) ? 3'd1 : 3'd0;
      end
      state_o.o_seen = rx_byte_i == wrbp_pkg::ChO;
      if (hit) begin
        result_o.ack_found     = 1'b1;
        state_o.byte_count     = '0;
        state_o.o_seen         = 1'b0;
        state_o.ready_progress = '0;
      end else begin
        state_o.byte_count = count_inc;
        if (count_inc >= overflow_limit_i) begin
          result_o.overflow      = 1'b1;
          state_o.byte_count     = '0;
          state_o.o_seen         = 1'b0;
          state_o.ready_progress = '0;
        end
      end
    end else begin
      if (state_i.byte_count >= overflow_limit_i) begin
        result_o.overflow      = 1'b1;
        count_pre              = '0;
        state_o.o_seen         = 1'b0;
        state_o.ready_progress = '0;
      end
      if (state_i.payload_remaining != 8'd0) begin
        result_o.cmd_valid        = 1'b1;
        result_o.cmd_byte         = rx_byte_i;
        result_o.cmd_index        = state_i.payload_position;
        result_o.cmd_last         = remaining_dec == 8'd0;
        state_o.payload_position  = state_i.payload_position + 8'd1;
        state_o.payload_remaining = remaining_dec;
      end
      if (count_pre > 8'd3 && state_i.recent[1] == 8'd0 && state_i.recent[0] == 8'd0 &&
          rx_byte_i != 8'd0) begin
        state_o.payload_remaining = rx_byte_i;
        state_o.payload_position  = '0;
      end
      state_o.byte_count = (count_pre == 8'hFF) ? 8'hFF : count_pre + 8'd1;
    end

    if (state_i.recent[2] == wrbp_pkg::LinkUp0 && state_i.recent[1] == wrbp_pkg::LinkUp1 &&
        state_i.recent[0] == 8'd0 && rx_byte_i == 8'd0) begin
      state_o.link_up = 1'b1;
    end
    if (state_i.recent[1] == wrbp_pkg::LinkDn0 && state_i.recent[0] == wrbp_pkg::LinkDn1 &&
        rx_byte_i == wrbp_pkg::LinkDn2) begin
      state_o.link_up = 1'b0;
    end
    state_o.recent     = {state_i.recent[1], state_i.recent[0], rx_byte_i};
    result_o.connected = state_o.link_up;
  end

endmodule

// File: design/wifi_response_byte_parser.sv
// Parses received serial bytes, one per transfer, and returns one result per byte: an
// acknowledge flag in command mode, a streamed command payload byte with its index and last
// mark in data mode, the link state and an overflow flag. A byte is taken in every cycle in
// which the result register is free or being read: all work is a short piece of logic from the
// parser state and the byte into the result register, so the throughput is one byte per clock
// unless stalled. The result register frees as it is read, so input is stalled only while a
// result waits and res_ready_i is low. Configuration writes are meant for idle periods.
module wifi_response_byte_parser (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wrbp_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [7:0]                         cfg_data_i,
  input  logic                               rx_valid_i,
  output logic                               rx_ready_o,
  input  logic [7:0]                         rx_byte_i,
  output logic                               res_valid_o,
  input  logic                               res_ready_i,
  output logic                               ack_found_o,
  output logic                               connected_o,
  output logic                               cmd_valid_o,
  output logic [7:0]                         cmd_byte_o,
  output logic [7:0]                         cmd_index_o,
  output logic                               cmd_last_o,
  output logic                               overflow_o
);

  logic                    command_mode_q;
  logic [7:0]              overflow_limit_q;
  wrbp_pkg::parse_state_t  state_q, state_d;
  wrbp_pkg::parse_result_t result_q, result_d;
  logic                    res_valid_q;
  logic                    rx_take;

  assign rx_ready_o = !res_valid_q || res_ready_i;
  assign rx_take    = rx_valid_i && rx_ready_o;

  wrbp_step u_step (
    .state_i          (state_q),
    .rx_byte_i        (rx_byte_i),
    .command_mode_i   (command_mode_q),
    .overflow_limit_i (overflow_limit_q),
    .state_o          (state_d),
    .result_o         (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      command_mode_q   <= wrbp_pkg::CommandModeReset;
      overflow_limit_q <= wrbp_pkg::OverflowLimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        wrbp_pkg::CFG_COMMAND_MODE:   command_mode_q   <= cfg_data_i[0];
        wrbp_pkg::CFG_OVERFLOW_LIMIT: overflow_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (rx_take) begin
        state_q <= state_d;
      end
      if (rx_take) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_take) begin
      result_q <= result_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign ack_found_o = result_q.ack_found;
  assign connected_o = result_q.connected;
  assign cmd_valid_o = result_q.cmd_valid;
  assign cmd_byte_o  = result_q.cmd_byte;
  assign cmd_index_o = result_q.cmd_index;
  assign cmd_last_o  = result_q.cmd_last;
  assign overflow_o  = result_q.overflow;

endmodule
